/* design/ecr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_pkg
// Shared constants and types for the elevation color ramp.
// ----------------------------------------------------------------------------
package ecr_pkg;

    localparam int MAX_STOPS  = 6;
    localparam int NUM_STOPS  = 6;
    localparam int ELEV_W     = 16;
    localparam int MAXE_W     = 15;
    localparam int CNT_W      = 3;
    localparam int POS_W      = 17;
    localparam int RGB_W      = 24;
    localparam int STOP_W     = POS_W + RGB_W;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_BITS  = 16;
    localparam int DIV1_W     = 32;
    localparam int FRAC_W     = DIV1_W + 1;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int SUM_W      = CH_W + POS_W;
    localparam int SEL_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ELEV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_COUNT = 3'd1;
    localparam int                   CFG_STOP_BASE  = 2;

    typedef struct packed {
        logic                v;
        logic                sign;
        logic [MAXE_W-1:0]   rem;
        logic [DIV1_W-1:0]   dvd;
        logic [DIV1_W-1:0]   quot;
    } t_div1;

    typedef struct packed {
        logic                     v;
        logic [NUM_CH-1:0][SUM_W-1:0] rem;
        logic [NUM_CH-1:0][CH_W-1:0]  quot;
        logic [POS_W-1:0]         den;
    } t_div2;

endpackage

/* design/elevation_color_ramp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elevation_color_ramp
// Signed elevation to RGB through a programmable piecewise linear gradient.
// ----------------------------------------------------------------------------
// One word per clock in while the skid entry is empty, one color word out per input.
// The output is registered. The pipe is built from the 32-step fraction divider and
// the 8-step per-channel interpolation divider, one quotient bit per stage.
// A two-entry output buffer lets the pipe keep moving after the sink stalls,
// until the skid entry fills. Stops must be written while no word is in flight.
module elevation_color_ramp
    import ecr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [STOP_W-1:0]    i_cfg_data,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [ELEV_W-1:0]    i_s_tdata,   // [15:0] elevation_sample
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [RGB_W-1:0]     o_m_tdata    // [7:0] blue, [15:8] green, [23:16] red
);

    logic [MAXE_W-1:0]              r_max_elev;
    logic [CNT_W-1:0]               r_stop_cnt;
    logic [NUM_STOPS-1:0][STOP_W-1:0] r_stops;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_elev <= MAXE_W'(1);
            r_stop_cnt <= CNT_W'(1);
            r_stops    <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_MAX_ELEV) begin
                r_max_elev <= i_cfg_data[MAXE_W-1:0];
            end else if (i_cfg_addr == CFG_STOP_COUNT) begin
                r_stop_cnt <= i_cfg_data[CNT_W-1:0];
            end else begin
                for (int k = 0; k < NUM_STOPS; k++) begin
                    if (i_cfg_addr == CFG_IDX_W'(CFG_STOP_BASE + k)) begin
                        r_stops[k] <= i_cfg_data;
                    end
                end
            end
        end
    end

    logic [MAXE_W-1:0]              w_div;
    logic [CNT_W-1:0]               w_n;
    logic [SEL_W-1:0]               w_last;
    logic [NUM_STOPS-1:0][POS_W-1:0] w_pos;
    logic [NUM_STOPS-1:0][RGB_W-1:0] w_rgb;

    always_comb begin
        w_div = (r_max_elev == '0) ? MAXE_W'(1) : r_max_elev;
        if (r_stop_cnt == '0) begin
            w_n = CNT_W'(1);
        end else if (r_stop_cnt > CNT_W'(MAX_STOPS)) begin
            w_n = CNT_W'(MAX_STOPS);
        end else begin
            w_n = r_stop_cnt;
        end
        w_last = SEL_W'(w_n - CNT_W'(1));
        for (int k = 0; k < NUM_STOPS; k++) begin
            w_pos[k] = r_stops[k][STOP_W-1:RGB_W];
            w_rgb[k] = r_stops[k][RGB_W-1:0];
        end
    end

    // output buffer and global advance
    logic              r_ov, r_sv;
    logic [RGB_W-1:0]  r_od, r_sd;
    logic              w_en;
    assign w_en       = !r_sv;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;

    // input stage
    t_div1 r_d1 [0:DIV1_W];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1[0].v <= 1'b0;
        end else if (w_en) begin
            r_d1[0].v <= i_s_tvalid;
        end
        if (w_en) begin
            r_d1[0].sign <= i_s_tdata[ELEV_W-1];
            r_d1[0].rem  <= '0;
            r_d1[0].quot <= '0;
            r_d1[0].dvd  <= {(i_s_tdata[ELEV_W-1] ? (ELEV_W'(0) - i_s_tdata) : i_s_tdata),
                             FRAC_BITS'(0)};
        end
    end

    // fraction divider, one quotient bit per stage
    for (genvar g = 0; g < DIV1_W; g++) begin : g_div1
        logic [MAXE_W:0] w_t;
        logic            w_ge;
        always_comb begin
            w_t  = {r_d1[g].rem, r_d1[g].dvd[DIV1_W-1]};
            w_ge = (w_t >= {1'b0, w_div});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d1[g+1].v <= 1'b0;
            end else if (w_en) begin
                r_d1[g+1].v <= r_d1[g].v;
            end
            if (w_en) begin
                r_d1[g+1].sign <= r_d1[g].sign;
                r_d1[g+1].rem  <= w_ge ? MAXE_W'(w_t - {1'b0, w_div}) : w_t[MAXE_W-1:0];
                r_d1[g+1].dvd  <= {r_d1[g].dvd[DIV1_W-2:0], 1'b0};
                r_d1[g+1].quot <= {r_d1[g].quot[DIV1_W-2:0], w_ge};
            end
        end
    end

    // signed fraction
    logic                     r_c_v;
    logic signed [FRAC_W-1:0] r_c_frac;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (w_en) begin
            r_c_v <= r_d1[DIV1_W].v;
        end
        if (w_en) begin
            r_c_frac <= r_d1[DIV1_W].sign ? (FRAC_W'(0) - {1'b0, r_d1[DIV1_W].quot})
                                          : {1'b0, r_d1[DIV1_W].quot};
        end
    end

    // compare against every stop
    logic                 r_d_v;
    logic [NUM_STOPS-1:0] r_d_le;
    logic                 r_d_ge;
    logic [POS_W-1:0]     r_d_frac;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_v <= 1'b0;
        end else if (w_en) begin
            r_d_v <= r_c_v;
        end
        if (w_en) begin
            for (int k = 0; k < NUM_STOPS; k++) begin
                r_d_le[k] <= r_c_frac <= $signed({(FRAC_W-POS_W)'(0), w_pos[k]});
            end
            r_d_ge   <= r_c_frac >= $signed({(FRAC_W-POS_W)'(0), w_pos[w_last]});
            r_d_frac <= r_c_frac[POS_W-1:0];
        end
    end

    // segment select; clamped words become color * 1 / 1
    logic                         r_e_v;
    logic [RGB_W-1:0]             r_e_a, r_e_b;
    logic [POS_W-1:0]             r_e_num, r_e_dn, r_e_den;
    logic [SEL_W-1:0]             w_sel;
    logic                         w_found;
    always_comb begin
        w_sel   = w_last;
        w_found = 1'b0;
        for (int k = 1; k < MAX_STOPS; k++) begin
            if (!w_found && (CNT_W'(k) < w_n) && r_d_le[k]) begin
                w_sel   = SEL_W'(k);
                w_found = 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= r_d_v;
        end
        if (w_en) begin
            priority if (r_d_le[0]) begin
                r_e_a <= w_rgb[0];  r_e_b <= w_rgb[0];
                r_e_num <= '0; r_e_dn <= POS_W'(1); r_e_den <= POS_W'(1);
            end else if (r_d_ge || !w_found) begin
                r_e_a <= w_rgb[w_last];  r_e_b <= w_rgb[w_last];
                r_e_num <= '0; r_e_dn <= POS_W'(1); r_e_den <= POS_W'(1);
            end else begin
                r_e_a   <= w_rgb[w_sel - SEL_W'(1)];
                r_e_b   <= w_rgb[w_sel];
                r_e_num <= r_d_frac - w_pos[w_sel - SEL_W'(1)];
                r_e_dn  <= w_pos[w_sel] - r_d_frac;
                r_e_den <= w_pos[w_sel] - w_pos[w_sel - SEL_W'(1)];
            end
        end
    end

    // weight products
    logic                             r_f_v;
    logic [NUM_CH-1:0][SUM_W-1:0]     r_f_p1, r_f_p2;
    logic [POS_W-1:0]                 r_f_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_v <= 1'b0;
        end else if (w_en) begin
            r_f_v <= r_e_v;
        end
        if (w_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_f_p1[c] <= r_e_a[c*CH_W +: CH_W] * r_e_dn;
                r_f_p2[c] <= r_e_b[c*CH_W +: CH_W] * r_e_num;
            end
            r_f_den <= r_e_den;
        end
    end

    // weighted sum feeds the interpolation divider
    t_div2 r_d2 [0:CH_W];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d2[0].v <= 1'b0;
        end else if (w_en) begin
            r_d2[0].v <= r_f_v;
        end
        if (w_en) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_d2[0].rem[c] <= SUM_W'(r_f_p1[c] + r_f_p2[c]);
            end
            r_d2[0].quot <= '0;
            r_d2[0].den  <= r_f_den;
        end
    end

    for (genvar g = 0; g < CH_W; g++) begin : g_div2
        logic [SUM_W-1:0]  w_dsh;
        logic [NUM_CH-1:0] w_ge;
        always_comb begin
            w_dsh = {(SUM_W-POS_W)'(0), r_d2[g].den} << (CH_W - 1 - g);
            for (int c = 0; c < NUM_CH; c++) begin
                w_ge[c] = r_d2[g].rem[c] >= w_dsh;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d2[g+1].v <= 1'b0;
            end else if (w_en) begin
                r_d2[g+1].v <= r_d2[g].v;
            end
            if (w_en) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    r_d2[g+1].rem[c]  <= w_ge[c] ? (r_d2[g].rem[c] - w_dsh) : r_d2[g].rem[c];
                    r_d2[g+1].quot[c] <= {r_d2[g].quot[c][CH_W-2:0], w_ge[c]};
                end
                r_d2[g+1].den <= r_d2[g].den;
            end
        end
    end

    logic [RGB_W-1:0] w_res;
    assign w_res = r_d2[CH_W].quot;

    logic w_take;
    assign w_take = r_ov && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            if (w_en && r_d2[CH_W].v) begin
                if (!r_ov || w_take) begin
                    r_ov <= 1'b1;
                    r_od <= w_res;
                end else begin
                    r_sv <= 1'b1;
                    r_sd <= w_res;
                end
            end else if (w_take) begin
                if (r_sv) begin
                    r_od <= r_sd;
                    r_sv <= 1'b0;
                end else begin
                    r_ov <= 1'b0;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov) else $error("skid full with empty output");
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_v |-> (r_e_den != '0)) else $error("zero segment width");
    a_weights_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_e_v |-> ((POS_W+1)'(r_e_num) + (POS_W+1)'(r_e_dn) == (POS_W+1)'(r_e_den)))
        else $error("segment weights do not add up");
    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d2[0].v |-> (r_d2[0].rem[0] < ({(SUM_W-POS_W)'(0), r_d2[0].den} << CH_W)))
        else $error("interpolation quotient overflow");
`endif

endmodule

/* tb/sv/ecr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecr_checker
// Watches the register writes and both streams of the color ramp, computes
// the color of every accepted elevation word and compares it with the output.
// ----------------------------------------------------------------------------
module ecr_checker
    import ecr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [STOP_W-1:0]    i_cfg_data,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [ELEV_W-1:0]    i_s_tdata,
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [RGB_W-1:0]     i_m_tdata,
    output int                   o_errors,
    output int                   o_pending
);

    logic [MAXE_W-1:0] max_elev;
    logic [CNT_W-1:0]  stop_cnt;
    logic [STOP_W-1:0] stop_reg [NUM_STOPS];
    logic [RGB_W-1:0]  color_q [$];

    function automatic longint pos_of(int i);
        return longint'(stop_reg[i][STOP_W-1:RGB_W]);
    endfunction

    function automatic logic [RGB_W-1:0] ramp_color(logic signed [ELEV_W-1:0] elev);
        longint frac, lo, num, den, a, b, maxe;
        int n;
        logic [RGB_W-1:0] c;
        maxe = (max_elev == 0) ? 1 : longint'(max_elev);
        frac = (longint'(elev) * 65536) / maxe;
        n = (stop_cnt == 0) ? 1 : (stop_cnt > MAX_STOPS ? MAX_STOPS : int'(stop_cnt));
        if (frac <= pos_of(0)) return stop_reg[0][RGB_W-1:0];
        if (frac >= pos_of(n - 1)) return stop_reg[n-1][RGB_W-1:0];
        c = stop_reg[n-1][RGB_W-1:0];
        for (int i = 1; i < n; i++) begin
            if (frac <= pos_of(i)) begin
                lo = pos_of(i - 1);
                num = frac - lo;
                den = pos_of(i) - lo;
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    a = longint'(stop_reg[i-1][ch*CH_W +: CH_W]);
                    b = longint'(stop_reg[i][ch*CH_W +: CH_W]);
                    c[ch*CH_W +: CH_W] = 8'((a * (den - num) + b * num) / den);
                end
                return c;
            end
        end
        return c;
    endfunction

    always @(posedge i_clk) begin
        logic [RGB_W-1:0] want;
        if (!i_rst_n) begin
            max_elev <= MAXE_W'(1);
            stop_cnt <= CNT_W'(1);
            for (int i = 0; i < NUM_STOPS; i++) stop_reg[i] <= '0;
            color_q.delete();
            o_errors <= 0;
            o_pending <= 0;
        end else begin
            if (i_s_tvalid && i_s_tready)
                color_q.insert(color_q.size(), ramp_color(i_s_tdata));
            if (i_m_tvalid && i_m_tready) begin
                if (color_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected word %h", i_m_tdata);
                    o_errors <= o_errors + 1;
                end else begin
                    want = color_q.pop_front();
                    if (want !== i_m_tdata) begin
                        if (o_errors < 10)
                            $display("color: exp b=%h g=%h r=%h got b=%h g=%h r=%h",
                                     want[7:0], want[15:8], want[23:16],
                                     i_m_tdata[7:0], i_m_tdata[15:8], i_m_tdata[23:16]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= color_q.size();
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_MAX_ELEV) max_elev <= i_cfg_data[MAXE_W-1:0];
                else if (i_cfg_addr == CFG_STOP_COUNT) stop_cnt <= i_cfg_data[CNT_W-1:0];
                else if (int'(i_cfg_addr) < CFG_STOP_BASE + NUM_STOPS)
                    stop_reg[int'(i_cfg_addr) - CFG_STOP_BASE] <= i_cfg_data;
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives elevation words through the color ramp under several gradients,
// with bursty input, a stalling sink and one long sink hold-off.
// ----------------------------------------------------------------------------
module tb;
    import ecr_pkg::*;

    logic                 i_clk, i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_addr;
    logic [STOP_W-1:0]    cfg_data;
    logic                 s_valid, s_ready, m_valid, m_ready;
    logic [ELEV_W-1:0]    s_data;
    logic [RGB_W-1:0]     m_data;
    int                   errors, pending, idle_cycles;
    bit                   hold_off;

    elevation_color_ramp dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_valid), .o_s_tready(s_ready), .i_s_tdata(s_data),
        .o_m_tvalid(m_valid), .i_m_tready(m_ready), .o_m_tdata(m_data)
    );

    ecr_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_s_tvalid(s_valid), .i_s_tready(s_ready), .i_s_tdata(s_data),
        .i_m_tvalid(m_valid), .i_m_tready(m_ready), .i_m_tdata(m_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        m_ready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                m_ready <= 0;
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end else if ($urandom_range(0, 7) < 5) m_ready <= 1;
            else m_ready <= ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // write enable stays high across back-to-back writes; send_word drops it
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [STOP_W-1:0] val);
        cfg_we <= 1; cfg_addr <= idx; cfg_data <= val;
        @(posedge i_clk);
    endtask

    function automatic logic [STOP_W-1:0] make_stop(int pos, logic [RGB_W-1:0] rgb);
        return {17'(pos), rgb};
    endfunction

    task automatic send_word(logic [ELEV_W-1:0] v);
        cfg_we <= 0;
        s_valid <= 1; s_data <= v;
        do @(posedge i_clk); while (!s_ready);
        if ($urandom_range(0, 5) == 0) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain;
        s_valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_words(int n, int range);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 3) == 0) send_word(16'($urandom));
            else send_word(16'($signed($urandom_range(0, 2 * range)) - range));
        end
    endtask

    task automatic ramp_setup(int maxe, int cnt, bit sorted);
        int p [NUM_STOPS];
        for (int i = 0; i < NUM_STOPS; i++) p[i] = $urandom_range(0, 65536);
        if ($urandom_range(0, 4) == 0) p[$urandom_range(0, 5)] = 131071;
        if (sorted) p.sort();
        write_reg(CFG_MAX_ELEV, STOP_W'(maxe));
        write_reg(CFG_STOP_COUNT, STOP_W'(cnt));
        for (int i = 0; i < NUM_STOPS; i++)
            write_reg(3'(CFG_STOP_BASE + i), make_stop(p[i], 24'($urandom)));
    endtask

    initial begin
        logic [ELEV_W-1:0] edge_vals [] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF,
                                            16'h0001, 16'h5555, 16'hAAAA};
        hold_off = 0;
        i_rst_n <= 0; cfg_we <= 0; cfg_addr <= '0; cfg_data <= '0;
        s_valid <= 0; s_data <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset gradient: single black stop
        foreach (edge_vals[i]) send_word(edge_vals[i]);
        drain();

        // directed gradient, full scale, six ascending stops
        write_reg(CFG_MAX_ELEV, STOP_W'(1000));
        write_reg(CFG_STOP_COUNT, STOP_W'(6));
        write_reg(3'(CFG_STOP_BASE + 0), make_stop(0, 24'h000000));
        write_reg(3'(CFG_STOP_BASE + 1), make_stop(13107, 24'hFFFFFF));
        write_reg(3'(CFG_STOP_BASE + 2), make_stop(26214, 24'h00FF00));
        write_reg(3'(CFG_STOP_BASE + 3), make_stop(39321, 24'hFF0000));
        write_reg(3'(CFG_STOP_BASE + 4), make_stop(52428, 24'h0000FF));
        write_reg(3'(CFG_STOP_BASE + 5), make_stop(65536, 24'hFFFFFF));
        foreach (edge_vals[i]) send_word(edge_vals[i]);
        send_word(16'd200); send_word(16'd1000); send_word(16'd1001);
        send_word(16'd333); send_word(16'd999); send_word(-16'sd5);
        drain();

        // zero maximum, zero and out-of-range counts
        write_reg(CFG_MAX_ELEV, STOP_W'(0));
        write_reg(CFG_STOP_COUNT, STOP_W'(0));
        send_word(16'd0); send_word(16'd1); send_word(16'h8000);
        drain();
        write_reg(CFG_MAX_ELEV, STOP_W'(32767));
        write_reg(CFG_STOP_COUNT, STOP_W'(7));
        write_reg(3'(CFG_STOP_BASE + 5), {17'h1FFFF, 24'hA5C3F0});
        send_word(16'h7FFF); send_word(16'h4000); send_word(16'h8000);
        drain();

        // long sink hold-off while the source keeps pushing
        hold_off = 1;
        random_words(80, 40000);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 3)
                0: ramp_setup($urandom_range(1, 2000), $urandom_range(2, 6), 1);
                1: ramp_setup(ph == 4 ? 32767 : $urandom_range(1, 32767), $urandom_range(0, 7), 1);
                default: ramp_setup(ph == 2 ? 1 : $urandom_range(1, 500), $urandom_range(2, 6), 0);
            endcase
            random_words(110, 3000);
            drain();
        end

        if (errors == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

/* sim.f */
design/ecr_pkg.sv
design/elevation_color_ramp.sv
tb/sv/ecr_checker.sv
tb/sv/tb.sv
